[rtl/llrq_pkg.sv]
`default_nettype none

package llrq_pkg;

    // field widths fixed by the item format
    localparam int CMD_W  = 2;
    localparam int ID_W   = 6;
    localparam int LINK_W = ID_W + 1;

    localparam int NUM_ENTRIES_DEF = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR     = 2'd0,
        CMD_INSERT    = 2'd1,
        CMD_REM_FIRST = 2'd2,
        CMD_REM_ENTRY = 2'd3
    } t_cmd;

    // one link table word: successor present flag over successor id
    typedef struct packed {
        logic            has;
        logic [ID_W-1:0] id;
    } t_link;

endpackage

`default_nettype wire

[rtl/llrq_ram.sv]
`default_nettype none

module llrq_ram #(
    parameter int WIDTH = llrq_pkg::LINK_W,
    parameter int DEPTH = llrq_pkg::NUM_ENTRIES_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/linked_list_ready_queue.sv]
// Channel  Dir  Handshake                Payload (low bit up)
// -------  ---  -----------------------  ----------------------------------------------
// s        in   i_s_tvalid / o_s_tready  tuser: command[1:0]; tdata: entry_id[5:0], pad
// m        out  o_m_tvalid / i_m_tready  tdata: removed_id[5:0], removed_valid[6],
//                                        head_id[12:7], queue_empty[13], pad
//
// o_s_tready is high only in the idle state; the sequencer takes one item at a time.
// Accept to result: clear, or a remove on an empty queue, goes straight to DONE; insert
// runs INS1 and INS2, remove-first CHK and CLR; remove-entry walks 1..NUM_ENTRIES entries
// in CHK at one link per cycle, then CLR on a hit; back to idle before the next item.
// Reset (synchronous, active low) empties the queue; the link table is not cleared.
// A stalled result holds in the output register while the next item runs; it then waits in DONE.
`default_nettype none

module linked_list_ready_queue #(
    parameter int NUM_ENTRIES = llrq_pkg::NUM_ENTRIES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input beats
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // entry_id[5:0], zeros[7:6]
    input  wire logic [1:0] i_s_tuser,   // command[1:0]
    // result beats
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [15:0]     o_m_tdata    // removed_id[5:0], removed_valid[6],
                                         // head_id[12:7], queue_empty[13], zeros[15:14]
);

    localparam int AW   = $clog2(NUM_ENTRIES);
    localparam int ID_W = llrq_pkg::ID_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_INS1 = 6'b000010,  // link old tail to new entry, or set head
        S_INS2 = 6'b000100,  // null link for new entry, move tail
        S_CHK  = 6'b001000,  // one visited link per cycle
        S_CLR  = 6'b010000,  // null link for removed entry
        S_DONE = 6'b100000   // load result register
    } t_state;

    t_state r_state, n_state;

    // list state
    logic [ID_W-1:0] r_head, n_head;
    logic [ID_W-1:0] r_tail, n_tail;
    logic            r_empty, n_empty;

    // per-item working registers
    llrq_pkg::t_cmd  r_cmd, n_cmd;
    logic [ID_W-1:0] r_id, n_id;
    logic [ID_W-1:0] r_cur, n_cur;
    logic [ID_W-1:0] r_prev, n_prev;
    logic            r_has_prev, n_has_prev;
    logic            r_first, n_first;
    logic [AW-1:0]   r_step, n_step;
    logic [ID_W-1:0] r_rem_id, n_rem_id;
    logic            r_rem_valid, n_rem_valid;

    // result register
    logic            r_out_valid, n_out_valid;
    logic [ID_W-1:0] r_o_rem_id, n_o_rem_id;
    logic            r_o_rem_valid, n_o_rem_valid;
    logic [ID_W-1:0] r_o_head, n_o_head;
    logic            r_o_empty, n_o_empty;

    // link table port
    logic                          w_we;
    logic [AW-1:0]                 w_waddr;
    llrq_pkg::t_link               w_wlink;
    logic [AW-1:0]                 w_raddr;
    logic [llrq_pkg::LINK_W-1:0]   w_rdata;
    llrq_pkg::t_link               w_rlink;

    logic            w_s_acc;
    llrq_pkg::t_cmd  w_in_cmd;
    logic [ID_W-1:0] w_in_id;
    logic            w_in_id_ok;
    logic            w_match;
    logic            w_out_free;

    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_in_cmd   = llrq_pkg::t_cmd'(i_s_tuser);
    assign w_in_id    = i_s_tdata[ID_W-1:0];
    assign w_in_id_ok = 32'(w_in_id) < NUM_ENTRIES;
    assign w_rlink    = llrq_pkg::t_link'(w_rdata);
    assign w_match    = r_first || (r_cur == r_id);
    assign w_out_free = !r_out_valid || i_m_tready;

    llrq_ram #(
        .WIDTH(llrq_pkg::LINK_W),
        .DEPTH(NUM_ENTRIES)
    ) u_link (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wlink),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_tail        = r_tail;
        n_empty       = r_empty;
        n_cmd         = r_cmd;
        n_id          = r_id;
        n_cur         = r_cur;
        n_prev        = r_prev;
        n_has_prev    = r_has_prev;
        n_first       = r_first;
        n_step        = r_step;
        n_rem_id      = r_rem_id;
        n_rem_valid   = r_rem_valid;
        n_out_valid   = r_out_valid;
        n_o_rem_id    = r_o_rem_id;
        n_o_rem_valid = r_o_rem_valid;
        n_o_head      = r_o_head;
        n_o_empty     = r_o_empty;

        w_we    = 1'b0;
        w_waddr = AW'(r_id);
        w_wlink = '0;
        // walk starts at the head; inside the walk the next address is the link just read
        w_raddr = AW'(r_head);

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_s_acc) begin
                    n_cmd       = w_in_cmd;
                    n_id        = w_in_id;
                    n_cur       = r_head;
                    n_has_prev  = 1'b0;
                    n_first     = (w_in_cmd == llrq_pkg::CMD_REM_FIRST);
                    n_step      = '0;
                    n_rem_id    = '0;
                    n_rem_valid = 1'b0;
                    unique case (w_in_cmd)
                        llrq_pkg::CMD_CLEAR: begin
                            n_head  = '0;
                            n_tail  = '0;
                            n_empty = 1'b1;
                            n_state = S_DONE;
                        end
                        llrq_pkg::CMD_INSERT: begin
                            n_state = w_in_id_ok ? S_INS1 : S_DONE;
                        end
                        llrq_pkg::CMD_REM_FIRST: begin
                            n_state = r_empty ? S_DONE : S_CHK;
                        end
                        llrq_pkg::CMD_REM_ENTRY: begin
                            n_state = (!r_empty && w_in_id_ok) ? S_CHK : S_DONE;
                        end
                    endcase
                end
            end

            S_INS1: begin
                if (r_empty) begin
                    n_head  = r_id;
                    n_empty = 1'b0;
                end else begin
                    w_we        = 1'b1;
                    w_waddr     = AW'(r_tail);
                    w_wlink.has = 1'b1;
                    w_wlink.id  = r_id;
                end
                n_state = S_INS2;
            end

            S_INS2: begin
                // null link written after the tail link: re-inserting the tail is a no-op
                w_we    = 1'b1;
                w_waddr = AW'(r_id);
                n_tail  = r_id;
                n_state = S_DONE;
            end

            S_CHK: begin
                if (w_match) begin
                    n_rem_id    = r_cur;
                    n_rem_valid = 1'b1;
                    if (!r_has_prev) begin
                        if (w_rlink.has) begin
                            n_head = w_rlink.id;
                        end else begin
                            n_empty = 1'b1;
                        end
                    end else begin
                        // splice predecessor past the removed entry
                        w_we    = 1'b1;
                        w_waddr = AW'(r_prev);
                        w_wlink = w_rlink;
                    end
                    // remove-first never looks at the tail
                    if (!r_first && (r_cur == r_tail)) begin
                        if (r_has_prev) begin
                            n_tail = r_prev;
                        end else begin
                            n_empty = 1'b1;
                        end
                    end
                    if (n_empty) begin
                        n_head = '0;
                        n_tail = '0;
                    end
                    n_state = S_CLR;
                end else if (!w_rlink.has || (r_step == AW'(NUM_ENTRIES - 1))) begin
                    // end of list, or walk bound reached
                    n_state = S_DONE;
                end else begin
                    w_raddr    = AW'(w_rlink.id);
                    n_prev     = r_cur;
                    n_has_prev = 1'b1;
                    n_cur      = w_rlink.id;
                    n_step     = r_step + AW'(1);
                end
            end

            S_CLR: begin
                w_we    = 1'b1;
                w_waddr = AW'(r_cur);
                n_state = S_DONE;
            end

            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_o_rem_id    = r_rem_valid ? r_rem_id : '0;
                    n_o_rem_valid = r_rem_valid;
                    n_o_head      = r_empty ? '0 : r_head;
                    n_o_empty     = r_empty;
                    n_state       = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and list state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_empty     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_empty     <= n_empty;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_id          <= n_id;
        r_cur         <= n_cur;
        r_prev        <= n_prev;
        r_has_prev    <= n_has_prev;
        r_first       <= n_first;
        r_step        <= n_step;
        r_rem_id      <= n_rem_id;
        r_rem_valid   <= n_rem_valid;
        r_o_rem_id    <= n_o_rem_id;
        r_o_rem_valid <= n_o_rem_valid;
        r_o_head      <= n_o_head;
        r_o_empty     <= n_o_empty;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_o_empty, r_o_head, r_o_rem_valid, r_o_rem_id};

`ifndef SYNTHESIS
    // an empty queue always holds head and tail at zero
    a_empty_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty |-> (r_head == '0) && (r_tail == '0))
        else $error("empty queue with nonzero head or tail");

    // clear goes straight to the result state with the queue empty
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && (w_in_cmd == llrq_pkg::CMD_CLEAR)) |=> (r_empty && (r_state == S_DONE)))
        else $error("clear did not empty the queue");

    // link table is written only by the insert, walk and unlink steps
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state != S_IDLE) && (r_state != S_DONE))
        else $error("link write outside a working state");

    // a result beat only appears out of the result state
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result beat raised outside the result state");

    // remove-first always matches on its first visit
    a_first_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CHK) && r_first) |=> (r_state == S_CLR))
        else $error("remove-first did not unlink the head");
`endif

endmodule

`default_nettype wire

[sim/tb_linked_list_ready_queue.sv]
module tb_linked_list_ready_queue;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_SLOTS = llrq_pkg::NUM_ENTRIES_DEF;
    localparam int ID_W       = llrq_pkg::ID_W;

    // result beat layout, first member at the top so it maps onto tdata[13:0]
    typedef struct packed {
        logic            queue_empty;
        logic [ID_W-1:0] head_id;
        logic            removed_valid;
        logic [ID_W-1:0] removed_id;
    } t_queue_result;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = '0;     // entry_id[5:0], zeros[7:6]
    logic [1:0]  i_s_tuser  = '0;     // command[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;           // removed_id[5:0], removed_valid[6],
                                      // head_id[12:7], queue_empty[13], zeros[15:14]

    linked_list_ready_queue #(
        .NUM_ENTRIES(LIST_SLOTS)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Behavioral copy of the list
    // ------------------------------------------------------------------
    llrq_pkg::t_link list_link [LIST_SLOTS];
    logic [ID_W-1:0] list_head  = '0;
    logic [ID_W-1:0] list_tail  = '0;
    logic            list_empty = 1'b1;

    t_queue_result pending_results[$];
    int            n_mismatch = 0;
    bit            tx_no_gaps = 1'b0;

    initial begin
        foreach (list_link[i]) list_link[i] = '0;
    end

    function automatic void clear_list();
        list_head  = '0;
        list_tail  = '0;
        list_empty = 1'b1;
    endfunction

    // append at the tail; the new entry always gets a null link
    function automatic void append_entry(logic [ID_W-1:0] id);
        if (list_empty) begin
            list_head  = id;
            list_empty = 1'b0;
        end else begin
            list_link[list_tail] = '{has: 1'b1, id: id};
        end
        list_tail     = id;
        list_link[id] = '0;
    endfunction

    function automatic bit pop_head(output logic [ID_W-1:0] got);
        llrq_pkg::t_link nxt;
        logic [ID_W-1:0] h;
        got = '0;
        if (list_empty) return 1'b0;
        h   = list_head;
        nxt = list_link[h];
        if (nxt.has) list_head = nxt.id;
        else clear_list();
        list_link[h] = '0;
        got = h;
        return 1'b1;
    endfunction

    // walk from the head, at most LIST_SLOTS links, and unlink id if met
    function automatic bit unlink_entry(logic [ID_W-1:0] id);
        logic [ID_W-1:0] cur;
        logic [ID_W-1:0] prev;
        llrq_pkg::t_link nxt;
        bit              has_prev;
        if (list_empty) return 1'b0;
        cur      = list_head;
        prev     = '0;
        has_prev = 1'b0;
        for (int unsigned step = 0; step < LIST_SLOTS; step++) begin
            nxt = list_link[cur];
            if (cur == id) begin
                if (!has_prev) begin
                    if (nxt.has) list_head = nxt.id;
                    else list_empty = 1'b1;
                end else begin
                    list_link[prev] = nxt;
                end
                if (cur == list_tail) begin
                    if (has_prev) list_tail = prev;
                    else list_empty = 1'b1;
                end
                if (list_empty) clear_list();
                list_link[cur] = '0;
                return 1'b1;
            end
            if (!nxt.has) return 1'b0;
            prev     = cur;
            has_prev = 1'b1;
            cur      = nxt.id;
        end
        return 1'b0;
    endfunction

    function automatic t_queue_result apply_command(llrq_pkg::t_cmd cmd, logic [ID_W-1:0] id);
        t_queue_result   res;
        logic [ID_W-1:0] got;
        bit              ok;
        res = '0;
        got = '0;
        ok  = 1'b0;
        case (cmd)
            llrq_pkg::CMD_CLEAR:     clear_list();
            llrq_pkg::CMD_INSERT:    append_entry(id);
            llrq_pkg::CMD_REM_FIRST: ok = pop_head(got);
            default: begin
                ok  = unlink_entry(id);
                got = id;
            end
        endcase
        res.removed_id    = ok ? got : '0;
        res.removed_valid = ok;
        res.head_id       = list_empty ? '0 : list_head;
        res.queue_empty   = list_empty;
        return res;
    endfunction

    // stimulus side views of the list, bounded like the hardware walk
    function automatic int list_size();
        logic [ID_W-1:0] cur;
        int n;
        if (list_empty) return 0;
        cur = list_head;
        n   = 1;
        while (list_link[cur].has && n < LIST_SLOTS) begin
            cur = list_link[cur].id;
            n++;
        end
        return n;
    endfunction

    function automatic logic [ID_W-1:0] list_entry(int pos);
        logic [ID_W-1:0] cur;
        cur = list_head;
        for (int k = 0; k < pos && list_link[cur].has; k++) cur = list_link[cur].id;
        return cur;
    endfunction

    function automatic bit list_holds(logic [ID_W-1:0] id);
        int n;
        n = list_size();
        for (int k = 0; k < n; k++) begin
            if (list_entry(k) == id) return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------
    // mostly back to back, some short gaps, rare long ones
    function automatic int pick_gap();
        int r;
        if (tx_no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // present one input beat and hold it until taken; tvalid stays high
    // across back-to-back beats
    task automatic push_command(llrq_pkg::t_cmd cmd, logic [ID_W-1:0] id);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {2'b00, id};
        do @(posedge i_clk); while (!o_s_tready);
        pending_results.push_back(apply_command(cmd, id));
    endtask

    function automatic logic [ID_W-1:0] any_id();
        return ID_W'($urandom_range(0, LIST_SLOTS - 1));
    endfunction

    // an id not on the list right now, if a few tries find one
    function automatic logic [ID_W-1:0] fresh_id();
        logic [ID_W-1:0] id;
        id = any_id();
        for (int k = 0; k < 16 && list_holds(id); k++) id = any_id();
        return id;
    endfunction

    // ------------------------------------------------------------------
    // Sink side: stretches of steady ready, short stalls and long stalls
    // ------------------------------------------------------------------
    initial begin : sink_stalls
        int mode;
        int span;
        int stall_left;
        stall_left = 0;
        forever begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(20, 200);
            repeat (span) begin
                @(posedge i_clk);
                if (stall_left > 0) begin
                    i_m_tready <= 1'b0;
                    stall_left--;
                end else begin
                    i_m_tready <= 1'b1;
                    if (mode == 1 && $urandom_range(0, 9) < 3)
                        stall_left = $urandom_range(1, 3);
                    else if (mode == 2 && $urandom_range(0, 19) == 0)
                        stall_left = $urandom_range(10, 40);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            n_mismatch++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_queue_result want;
        t_queue_result got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[13:0];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat, actual %h", $time, o_m_tdata);
                n_mismatch++;
            end else begin
                want = pending_results.pop_front();
                check_field("removed_id",    want.removed_id,    got.removed_id);
                check_field("removed_valid", want.removed_valid, got.removed_valid);
                check_field("head_id",       want.head_id,       got.head_id);
                check_field("queue_empty",   want.queue_empty,   got.queue_empty);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // corner cases on short lists
    task automatic run_directed();
        push_command(llrq_pkg::CMD_REM_FIRST, any_id());  // pop on empty queue
        push_command(llrq_pkg::CMD_REM_ENTRY, 6'd5);      // lookup on empty queue
        push_command(llrq_pkg::CMD_CLEAR,     any_id());  // clear when already empty
        push_command(llrq_pkg::CMD_INSERT,    6'd0);
        push_command(llrq_pkg::CMD_INSERT,    6'd0);      // re-insert of the tail: no change
        push_command(llrq_pkg::CMD_REM_ENTRY, 6'd0);      // lone head -> empty
        push_command(llrq_pkg::CMD_INSERT,    6'd63);
        push_command(llrq_pkg::CMD_INSERT,    6'd21);
        push_command(llrq_pkg::CMD_INSERT,    6'd42);
        push_command(llrq_pkg::CMD_REM_ENTRY, 6'd7);      // miss after a full walk
        push_command(llrq_pkg::CMD_REM_ENTRY, 6'd42);     // tail with predecessor
        push_command(llrq_pkg::CMD_INSERT,    6'd42);
        push_command(llrq_pkg::CMD_REM_ENTRY, 6'd21);     // middle entry
        push_command(llrq_pkg::CMD_REM_ENTRY, 6'd63);     // head with successor
        push_command(llrq_pkg::CMD_REM_FIRST, any_id());  // last entry -> empty
        push_command(llrq_pkg::CMD_INSERT,    6'd10);
        push_command(llrq_pkg::CMD_INSERT,    6'd11);
        push_command(llrq_pkg::CMD_INSERT,    6'd12);
        push_command(llrq_pkg::CMD_INSERT,    6'd10);     // duplicate of the head cuts the chain
        push_command(llrq_pkg::CMD_REM_ENTRY, 6'd11);     // orphaned entry is not found
        push_command(llrq_pkg::CMD_REM_FIRST, any_id());
        push_command(llrq_pkg::CMD_INSERT,    6'd33);
        push_command(llrq_pkg::CMD_INSERT,    6'd34);
        push_command(llrq_pkg::CMD_CLEAR,     any_id());  // clear with live contents
        push_command(llrq_pkg::CMD_INSERT,    6'd35);     // stale links must not be followed
        push_command(llrq_pkg::CMD_REM_FIRST, any_id());
    endtask

    // every slot queued, then walks of full length
    task automatic run_full_list();
        int              order [LIST_SLOTS];
        int              j;
        int              tmp;
        logic [ID_W-1:0] last_id;
        foreach (order[i]) order[i] = i;
        for (int i = LIST_SLOTS - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        foreach (order[i]) push_command(llrq_pkg::CMD_INSERT, ID_W'(order[i]));
        last_id = list_tail;
        push_command(llrq_pkg::CMD_REM_ENTRY, last_id);   // longest hit
        push_command(llrq_pkg::CMD_REM_ENTRY, last_id);   // longest miss
        push_command(llrq_pkg::CMD_INSERT,    last_id);
        repeat (8) push_command(llrq_pkg::CMD_REM_FIRST, any_id());
        while (!list_empty) begin
            push_command(llrq_pkg::CMD_REM_ENTRY,
                         list_entry($urandom_range(0, list_size() - 1)));
        end
        push_command(llrq_pkg::CMD_REM_ENTRY, any_id());  // drained: empty again
    endtask

    // grow and drain phases keep lists deep; some noise on top
    task automatic run_random(int n_items);
        int insert_pct;
        int r;
        int n;
        for (int i = 0; i < n_items; i++) begin
            if (i % 100 == 0) begin
                insert_pct = (i / 100) % 2 == 0 ? 65 : 25;
                tx_no_gaps = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            n = list_size();
            if (r < insert_pct) begin
                if ($urandom_range(0, 19) == 0) push_command(llrq_pkg::CMD_INSERT, any_id());
                else push_command(llrq_pkg::CMD_INSERT, fresh_id());
            end else if (r < insert_pct + 12) begin
                push_command(llrq_pkg::CMD_REM_FIRST, any_id());
            end else if (r < 97) begin
                if (n > 0 && $urandom_range(0, 3) != 0)
                    push_command(llrq_pkg::CMD_REM_ENTRY, list_entry($urandom_range(0, n - 1)));
                else
                    push_command(llrq_pkg::CMD_REM_ENTRY, any_id());
            end else begin
                push_command(llrq_pkg::CMD_CLEAR, any_id());
            end
        end
        tx_no_gaps = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_full_list();
        run_random(1650);

        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // room for a stray extra beat to show up
        repeat (100) @(posedge i_clk);

        if (n_mismatch == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
